// File: hw/rtl/vfv_pkg.sv
package vfv_pkg;

   localparam int COORD_W = 4;
   localparam int VOXEL_W = 8;
   localparam int FACE_N = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [VOXEL_W-1:0] voxel_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [FACE_N-1:0]  face_mask_type;

   // face numbers double as halo plane numbers
   typedef logic [2:0] face_type;
   localparam face_type FACE_XL = 3'd0;
   localparam face_type FACE_XH = 3'd1;
   localparam face_type FACE_ZL = 3'd2;
   localparam face_type FACE_ZH = 3'd3;
   localparam face_type FACE_YL = 3'd4;
   localparam face_type FACE_YH = 3'd5;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_HALO  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      JOB_NOP,
      JOB_CHUNK_WR,
      JOB_HALO_WR,
      JOB_QUERY
   } job_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LAST
   } back_state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] side;
      coord_type  x;
      coord_type  y;
      coord_type  z;
      voxel_type  block_value;
   } req_type;

   typedef struct packed {
      face_mask_type face_mask;
      face_mask_type neighbor_dirty;
      logic          self_dirty;
   } rsp_type;

   typedef struct packed {
      job_kind_type  kind;
      face_type      side;
      coord_type     x;
      coord_type     y;
      coord_type     z;
      voxel_type     value;
      face_mask_type at_bound;
   } job_type;

endpackage

// File: hw/rtl/vfv_chan_if.sv
interface vfv_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/vfv_front.sv
module vfv_front
   import vfv_pkg::*;
#(
   parameter int SIDE_W = 16,
   parameter int SIDE_D = 16,
   parameter int SIDE_H = 16
) (
   vfv_chan_if.sink   req_ch,
   output logic       push_valid,
   input  logic       push_ready,
   output job_type    push_job
);

   logic in_chunk;
   logic halo_ok;

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      in_chunk = (int'(req_ch.payload.x) < SIDE_W) && (int'(req_ch.payload.y) < SIDE_H) &&
                 (int'(req_ch.payload.z) < SIDE_D);

      // the coordinate across the plane does not matter
      unique case (req_ch.payload.side) inside
         FACE_XL, FACE_XH: begin
            halo_ok = (int'(req_ch.payload.y) < SIDE_H) && (int'(req_ch.payload.z) < SIDE_D);
         end
         FACE_ZL, FACE_ZH: begin
            halo_ok = (int'(req_ch.payload.x) < SIDE_W) && (int'(req_ch.payload.y) < SIDE_H);
         end
         FACE_YL, FACE_YH: begin
            halo_ok = (int'(req_ch.payload.x) < SIDE_W) && (int'(req_ch.payload.z) < SIDE_D);
         end
         default: begin
            halo_ok = 1'b0;
         end
      endcase

      push_job.kind  = JOB_NOP;
      push_job.side  = req_ch.payload.side;
      push_job.x     = req_ch.payload.x;
      push_job.y     = req_ch.payload.y;
      push_job.z     = req_ch.payload.z;
      push_job.value = req_ch.payload.block_value;
      push_job.at_bound = {
         int'(req_ch.payload.y) == SIDE_H - 1,
         req_ch.payload.y == '0,
         int'(req_ch.payload.z) == SIDE_D - 1,
         req_ch.payload.z == '0,
         int'(req_ch.payload.x) == SIDE_W - 1,
         req_ch.payload.x == '0
      };

      unique case (req_ch.payload.cmd)
         CMD_WRITE: begin
            if (in_chunk) push_job.kind = JOB_CHUNK_WR;
         end
         CMD_HALO: begin
            if (halo_ok) push_job.kind = JOB_HALO_WR;
         end
         CMD_QUERY: begin
            if (in_chunk) push_job.kind = JOB_QUERY;
         end
         default: begin
            push_job.kind = JOB_NOP;
         end
      endcase
   end

endmodule

// File: hw/rtl/vfv_queue.sv
module vfv_queue
   import vfv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// File: hw/rtl/vfv_back.sv
module vfv_back
   import vfv_pkg::*;
#(
   parameter int SIDE_W = 16,
   parameter int SIDE_D = 16,
   parameter int SIDE_H = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  job_type    pop_job,
   vfv_chan_if.source rsp_ch,
   vfv_chan_if.sink   csr_ch
);

   localparam int CHUNK_N  = SIDE_W * SIDE_H * SIDE_D;
   localparam int XPLANE   = SIDE_H * SIDE_D;
   localparam int ZPLANE   = SIDE_W * SIDE_H;
   localparam int YPLANE   = SIDE_W * SIDE_D;
   localparam int OFF_XL   = 0;
   localparam int OFF_XH   = OFF_XL + XPLANE;
   localparam int OFF_ZL   = OFF_XH + XPLANE;
   localparam int OFF_ZH   = OFF_ZL + ZPLANE;
   localparam int OFF_YL   = OFF_ZH + ZPLANE;
   localparam int OFF_YH   = OFF_YL + YPLANE;
   localparam int HALO_N   = OFF_YH + YPLANE;
   localparam int CHUNK_AW = $clog2(CHUNK_N);
   localparam int HALO_AW  = $clog2(HALO_N);
   // one spare bit so a neighbor coordinate above fifteen still fits
   localparam int CW       = COORD_W + 1;

   function automatic logic [CHUNK_AW-1:0] chunk_idx(logic [CW-1:0] cx, logic [CW-1:0] cy,
                                                     logic [CW-1:0] cz);
      return (CHUNK_AW'(cy) * CHUNK_AW'(SIDE_D) + CHUNK_AW'(cz)) * CHUNK_AW'(SIDE_W) +
             CHUNK_AW'(cx);
   endfunction

   function automatic logic [HALO_AW-1:0] halo_idx(face_type plane, coord_type cx,
                                                   coord_type cy, coord_type cz);
      logic [HALO_AW-1:0] pos;
      logic [HALO_AW-1:0] base;
      unique case (plane) inside
         FACE_XL, FACE_XH: pos = HALO_AW'(cy) * HALO_AW'(SIDE_D) + HALO_AW'(cz);
         FACE_ZL, FACE_ZH: pos = HALO_AW'(cy) * HALO_AW'(SIDE_W) + HALO_AW'(cx);
         default:          pos = HALO_AW'(cz) * HALO_AW'(SIDE_W) + HALO_AW'(cx);
      endcase
      unique case (plane)
         FACE_XL: base = HALO_AW'(OFF_XL);
         FACE_XH: base = HALO_AW'(OFF_XH);
         FACE_ZL: base = HALO_AW'(OFF_ZL);
         FACE_ZH: base = HALO_AW'(OFF_ZH);
         FACE_YL: base = HALO_AW'(OFF_YL);
         default: base = HALO_AW'(OFF_YH);
      endcase
      return base + pos;
   endfunction

   voxel_type           chunk_mem [CHUNK_N];
   voxel_type           halo_mem [HALO_N];

   back_state_type      state_ff, state_in;
   face_type            step_ff, step_in;
   job_type             job_ff;
   logic                load_job;
   logic                rd_sel_ff, rd_sel_in;
   logic                center_full_ff, center_full_in;
   face_mask_type       mask_ff, mask_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   voxel_type           empty_code_ff;
   voxel_type           chunk_rd_ff;
   voxel_type           halo_rd_ff;

   logic                chunk_we, chunk_re;
   logic                halo_we, halo_re;
   logic [CHUNK_AW-1:0] chunk_addr;
   logic [HALO_AW-1:0]  halo_addr;
   logic                out_free;
   logic                out_load;
   rsp_type             out_data;
   voxel_type           rd_val;
   logic                rd_is_empty;
   face_type            prev_face;
   logic [CW-1:0]       nx, ny, nz;
   face_mask_type       mask_fin;

   assign out_free       = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;
   assign csr_ch.ready   = 1'b1;
   assign rd_val         = rd_sel_ff ? halo_rd_ff : chunk_rd_ff;
   assign rd_is_empty    = rd_val == empty_code_ff;
   assign prev_face      = step_ff - 1'b1;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      rd_sel_in      = rd_sel_ff;
      center_full_in = center_full_ff;
      mask_in        = mask_ff;
      load_job       = 1'b0;
      pop_ready      = 1'b0;
      chunk_we       = 1'b0;
      chunk_re       = 1'b0;
      halo_we        = 1'b0;
      halo_re        = 1'b0;
      chunk_addr     = chunk_idx({1'b0, pop_job.x}, {1'b0, pop_job.y}, {1'b0, pop_job.z});
      halo_addr      = halo_idx(pop_job.side, pop_job.x, pop_job.y, pop_job.z);
      out_load       = 1'b0;
      out_data       = '0;
      mask_fin       = mask_ff;
      nx             = {1'b0, job_ff.x};
      ny             = {1'b0, job_ff.y};
      nz             = {1'b0, job_ff.z};

      unique case (step_ff)
         FACE_XL: nx = nx - 1'b1;
         FACE_XH: nx = nx + 1'b1;
         FACE_ZL: nz = nz - 1'b1;
         FACE_ZH: nz = nz + 1'b1;
         FACE_YL: ny = ny - 1'b1;
         default: ny = ny + 1'b1;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_job.kind == JOB_QUERY) begin
                  // center read goes out in the pop cycle
                  pop_ready = 1'b1;
                  load_job  = 1'b1;
                  chunk_re  = 1'b1;
                  rd_sel_in = 1'b0;
                  mask_in   = '0;
                  step_in   = FACE_XL;
                  state_in  = ST_READ;
               end else if (out_free) begin
                  pop_ready = 1'b1;
                  out_load  = 1'b1;
                  chunk_we  = pop_job.kind == JOB_CHUNK_WR;
                  halo_we   = pop_job.kind == JOB_HALO_WR;
                  if (pop_job.kind == JOB_CHUNK_WR) begin
                     out_data.neighbor_dirty = pop_job.at_bound;
                     out_data.self_dirty     = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            // collect the beat issued last cycle
            if (step_ff == FACE_XL) begin
               center_full_in = !rd_is_empty;
            end else begin
               mask_in[prev_face] = rd_is_empty;
            end
            chunk_addr = chunk_idx(nx, ny, nz);
            halo_addr  = halo_idx(step_ff, job_ff.x, job_ff.y, job_ff.z);
            rd_sel_in  = job_ff.at_bound[step_ff];
            halo_re    = job_ff.at_bound[step_ff];
            chunk_re   = !job_ff.at_bound[step_ff];
            step_in    = step_ff + 1'b1;
            if (step_ff == FACE_YH) state_in = ST_LAST;
         end
         ST_LAST: begin
            mask_fin[FACE_YH] = rd_is_empty;
            if (out_free) begin
               out_load           = 1'b1;
               out_data.face_mask = center_full_ff ? mask_fin : '0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= FACE_XL;
         rsp_valid_ff  <= 1'b0;
         empty_code_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_ch.valid) empty_code_ff <= csr_ch.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) job_ff <= pop_job;
      if (out_load) rsp_data_ff <= out_data;
      if (chunk_re || halo_re) rd_sel_ff <= rd_sel_in;
      center_full_ff <= center_full_in;
      mask_ff        <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (chunk_we) chunk_mem[chunk_addr] <= pop_job.value;
      if (chunk_re) chunk_rd_ff <= chunk_mem[chunk_addr];
   end

   always_ff @(posedge clock) begin
      if (halo_we) halo_mem[halo_addr] <= pop_job.value;
      if (halo_re) halo_rd_ff <= halo_mem[halo_addr];
   end

`ifndef ASSERT_OFF
   a_read_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_READ || state_ff == ST_LAST)
      else $error("read sequence left early");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && pop_valid && pop_job.kind == JOB_QUERY
      |=> state_ff == ST_READ && step_ff == FACE_XL)
      else $error("query did not start its read sequence");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !chunk_we && !halo_we)
      else $error("write during query");

   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LAST && !out_free |=> state_ff == ST_LAST && $stable(rd_val))
      else $error("final neighbor beat lost while stalled");

   a_dirty_no_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.self_dirty |-> rsp_data_ff.face_mask == '0)
      else $error("write result carries a face mask");
`endif

endmodule

// File: hw/rtl/voxel_face_visibility.sv
// voxel face visibility: hidden-face culling for one chunk plus its six halo planes
// req_ch carries commands: write chunk voxel, write halo voxel, query face mask.
// rsp_ch returns exactly one beat per request beat, in request order.
// csr_ch writes the empty voxel code; it is always ready and should only be
// written while no request is in flight.
// a front stage classifies each request and range-checks its coordinates, a
// two-entry queue decouples it from the back end, which owns the chunk and halo
// memories and the result register.
// writes and ignored commands load the result when popped; a query reads its
// center on the pop, a neighbor per ST_READ step, then the result in ST_LAST.
// one write per cycle while rsp_ch is ready; a query holds the back end, as the
// memories' single read port serves center plus six neighbors, one read a cycle.
// reset clears control state and sets the empty code to zero; memory contents
// stay undefined until written.
// a stalled rsp_ch holds its beat; the queue keeps taking requests until full.
module voxel_face_visibility
   import vfv_pkg::*;
#(
   parameter int SIDE_W = 16,
   parameter int SIDE_D = 16,
   parameter int SIDE_H = 16
) (
   input  logic       clock,
   input  logic       reset,
   vfv_chan_if.sink   req_ch,
   vfv_chan_if.source rsp_ch,
   vfv_chan_if.sink   csr_ch
);

   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   vfv_front #(
      .SIDE_W (SIDE_W),
      .SIDE_D (SIDE_D),
      .SIDE_H (SIDE_H)
   ) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   vfv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   vfv_back #(
      .SIDE_W (SIDE_W),
      .SIDE_D (SIDE_D),
      .SIDE_H (SIDE_H)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_ch    (rsp_ch),
      .csr_ch    (csr_ch)
   );

endmodule

// File: tb/voxel_face_visibility_tb.sv
`timescale 1ns / 1ps

module voxel_face_visibility_tb;
   import vfv_pkg::*;

   localparam int SIDE = 16;
   localparam coord_type COORD_MAX = coord_type'(SIDE - 1);
   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int PHASE_N = 4;
   localparam int PHASE_ITEMS = 340;
   localparam int CALM_ITEMS = 150;
   localparam int HOLD_AT = 500;
   localparam int HOLD_CYCLES = 100;
   localparam int STUCK_LIMIT = 3000;
   localparam int IDLE_PCT = 23;

   // running copy of the chunk, the halo planes and the empty code
   class cull_tracker;
      voxel_type chunk[SIDE*SIDE*SIDE];
      voxel_type halo[FACE_N][SIDE*SIDE];
      voxel_type empty_code = '0;
      rsp_type owed[$];
      int mismatches = 0;

      static function logic [7:0] plane_slot(face_type s, coord_type x, coord_type y,
                                             coord_type z);
         case (s)
            FACE_XL, FACE_XH: return {y, z};
            FACE_ZL, FACE_ZH: return {y, x};
            default: return {z, x};
         endcase
      endfunction

      function void set_empty(voxel_type v);
         empty_code = v;
      endfunction

      function face_mask_type visible_faces(coord_type x, coord_type y, coord_type z);
         voxel_type nb[FACE_N];
         face_mask_type m;
         coord_type xm, xp, ym, yp, zm, zp;
         xm = x - 1'b1;
         xp = x + 1'b1;
         ym = y - 1'b1;
         yp = y + 1'b1;
         zm = z - 1'b1;
         zp = z + 1'b1;
         nb[FACE_XL] = (x == '0) ? halo[FACE_XL][plane_slot(FACE_XL, x, y, z)]
                                 : chunk[{y, z, xm}];
         nb[FACE_XH] = (x == COORD_MAX) ? halo[FACE_XH][plane_slot(FACE_XH, x, y, z)]
                                        : chunk[{y, z, xp}];
         nb[FACE_ZL] = (z == '0) ? halo[FACE_ZL][plane_slot(FACE_ZL, x, y, z)]
                                 : chunk[{y, zm, x}];
         nb[FACE_ZH] = (z == COORD_MAX) ? halo[FACE_ZH][plane_slot(FACE_ZH, x, y, z)]
                                        : chunk[{y, zp, x}];
         nb[FACE_YL] = (y == '0) ? halo[FACE_YL][plane_slot(FACE_YL, x, y, z)]
                                 : chunk[{ym, z, x}];
         nb[FACE_YH] = (y == COORD_MAX) ? halo[FACE_YH][plane_slot(FACE_YH, x, y, z)]
                                        : chunk[{yp, z, x}];
         for (int f = 0; f < FACE_N; f++)
            m[f] = (nb[f] == empty_code);
         return m;
      endfunction

      function void take_request(req_type r);
         rsp_type res;
         res = '0;
         case (r.cmd)
            CMD_WRITE: begin
               chunk[{r.y, r.z, r.x}] = r.block_value;
               res.self_dirty = 1'b1;
               res.neighbor_dirty[FACE_XL] = (r.x == '0);
               res.neighbor_dirty[FACE_XH] = (r.x == COORD_MAX);
               res.neighbor_dirty[FACE_ZL] = (r.z == '0);
               res.neighbor_dirty[FACE_ZH] = (r.z == COORD_MAX);
               res.neighbor_dirty[FACE_YL] = (r.y == '0);
               res.neighbor_dirty[FACE_YH] = (r.y == COORD_MAX);
            end
            CMD_HALO: begin
               if (r.side <= FACE_YH)
                  halo[r.side][plane_slot(r.side, r.x, r.y, r.z)] = r.block_value;
            end
            CMD_QUERY: begin
               if (chunk[{r.y, r.z, r.x}] != empty_code)
                  res.face_mask = visible_faces(r.x, r.y, r.z);
            end
            default: ;
         endcase
         owed.push_back(res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            $error("result beat with nothing outstanding: %0h", got);
            mismatches++;
            return;
         end
         want = owed.pop_front();
         if (got.face_mask !== want.face_mask) begin
            $error("face_mask: expected %0h, got %0h", want.face_mask, got.face_mask);
            mismatches++;
         end
         if (got.neighbor_dirty !== want.neighbor_dirty) begin
            $error("neighbor_dirty: expected %0h, got %0h", want.neighbor_dirty,
                   got.neighbor_dirty);
            mismatches++;
         end
         if (got.self_dirty !== want.self_dirty) begin
            $error("self_dirty: expected %0h, got %0h", want.self_dirty, got.self_dirty);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   vfv_chan_if #(.payload_type(req_type))   req_ch ();
   vfv_chan_if #(.payload_type(rsp_type))   rsp_ch ();
   vfv_chan_if #(.payload_type(voxel_type)) csr_ch ();

   voxel_face_visibility #(
      .SIDE_W(SIDE),
      .SIDE_D(SIDE),
      .SIDE_H(SIDE)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cull_tracker tracker = new();

   // which entries the stimulus has written, so queries never touch unwritten ones
   bit chunk_set[SIDE*SIDE*SIDE];
   bit halo_set[FACE_N][SIDE*SIDE];
   voxel_type empty_now = '0;
   int items_sent = 0;
   int req_seen = 0;
   int stuck = 0;
   int hold_left = 0;
   bit hold_done = 0;
   bit calm = 0;
   bit moved;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      moved = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result(rsp_ch.payload);
            moved = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.take_request(req_ch.payload);
            req_seen++;
            moved = 1'b1;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            tracker.set_empty(csr_ch.payload);
            moved = 1'b1;
         end
      end
      stuck = moved ? 0 : stuck + 1;
      if (stuck > STUCK_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off so the block backs up
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && req_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic send_req(input req_type r);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic voxel_type pick_value();
      if ($urandom_range(99) < 40)
         return empty_now;
      return voxel_type'($urandom_range(255));
   endfunction

   function automatic voxel_type fill_value(bit solid);
      voxel_type v;
      if (!solid)
         return pick_value();
      do v = voxel_type'($urandom_range(255)); while (v == empty_now);
      return v;
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(3))
         0: return coord_type'($urandom_range(2));
         1: return coord_type'($urandom_range(SIDE - 1, SIDE - 3));
         default: return coord_type'($urandom_range(SIDE - 1));
      endcase
   endfunction

   task automatic put_voxel(input coord_type x, input coord_type y, input coord_type z,
                            input voxel_type v);
      req_type r;
      r = '0;
      r.cmd = CMD_WRITE;
      r.side = 3'($urandom_range(7));
      r.x = x;
      r.y = y;
      r.z = z;
      r.block_value = v;
      chunk_set[{y, z, x}] = 1'b1;
      items_sent++;
      send_req(r);
   endtask

   // the coordinate across the plane is don't-care, so it gets noise
   task automatic put_halo(input face_type s, input coord_type x, input coord_type y,
                           input coord_type z, input voxel_type v);
      req_type r;
      r = '0;
      r.cmd = CMD_HALO;
      r.side = s;
      r.x = (s == FACE_XL || s == FACE_XH) ? coord_type'($urandom_range(15)) : x;
      r.z = (s == FACE_ZL || s == FACE_ZH) ? coord_type'($urandom_range(15)) : z;
      r.y = (s == FACE_YL || s == FACE_YH) ? coord_type'($urandom_range(15)) : y;
      r.block_value = v;
      halo_set[s][cull_tracker::plane_slot(s, x, y, z)] = 1'b1;
      items_sent++;
      send_req(r);
   endtask

   task automatic ask_faces(input coord_type x, input coord_type y, input coord_type z,
                            input bit solid);
      req_type r;
      coord_type nx, ny, nz;
      bit at_plane;
      if (!chunk_set[{y, z, x}])
         put_voxel(x, y, z, fill_value(solid));
      for (int f = 0; f < FACE_N; f++) begin
         nx = x;
         ny = y;
         nz = z;
         at_plane = 1'b0;
         case (face_type'(f))
            FACE_XL: if (x == '0) at_plane = 1'b1; else nx = x - 1'b1;
            FACE_XH: if (x == COORD_MAX) at_plane = 1'b1; else nx = x + 1'b1;
            FACE_ZL: if (z == '0) at_plane = 1'b1; else nz = z - 1'b1;
            FACE_ZH: if (z == COORD_MAX) at_plane = 1'b1; else nz = z + 1'b1;
            FACE_YL: if (y == '0) at_plane = 1'b1; else ny = y - 1'b1;
            default: if (y == COORD_MAX) at_plane = 1'b1; else ny = y + 1'b1;
         endcase
         if (at_plane) begin
            if (!halo_set[f][cull_tracker::plane_slot(face_type'(f), x, y, z)])
               put_halo(face_type'(f), x, y, z, fill_value(solid));
         end else if (!chunk_set[{ny, nz, nx}]) begin
            put_voxel(nx, ny, nz, fill_value(solid));
         end
      end
      r = '0;
      r.cmd = CMD_QUERY;
      r.side = 3'($urandom_range(7));
      r.x = x;
      r.y = y;
      r.z = z;
      r.block_value = voxel_type'($urandom_range(255));
      items_sent++;
      send_req(r);
   endtask

   // beats the block answers with an all-zero result: reserved command, or halo side past the last plane
   task automatic send_ignored(input bit reserved_cmd);
      req_type r;
      r.cmd = reserved_cmd ? CMD_RESERVED : CMD_HALO;
      r.side = reserved_cmd ? 3'($urandom_range(7)) : 3'($urandom_range(7, FACE_YH + 1));
      r.x = coord_type'($urandom_range(15));
      r.y = coord_type'($urandom_range(15));
      r.z = coord_type'($urandom_range(15));
      r.block_value = voxel_type'($urandom_range(255));
      send_req(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.owed.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_empty_code(input voxel_type v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= v;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      empty_now = v;
   endtask

   task automatic random_beat();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)
         ask_faces(pick_coord(), pick_coord(), pick_coord(), $urandom_range(9) == 0);
      else if (pick < 70)
         put_voxel(pick_coord(), pick_coord(), pick_coord(), pick_value());
      else if (pick < 90)
         put_halo(face_type'($urandom_range(FACE_YH)), coord_type'($urandom_range(15)),
                  coord_type'($urandom_range(15)), coord_type'($urandom_range(15)),
                  pick_value());
      else
         send_ignored($urandom_range(1));
   endtask

   initial begin
      voxel_type phase_code[PHASE_N];
      int phase_start;
      phase_code[0] = 8'h00;
      phase_code[1] = 8'hFF;
      phase_code[2] = voxel_type'($urandom_range(254, 1));
      phase_code[3] = 8'h00;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_empty_code(phase_code[0]);

      // corners first: both ends of every coordinate, halo on the low planes
      put_voxel(4'd0, 4'd0, 4'd0, 8'hFF);
      put_voxel(COORD_MAX, COORD_MAX, COORD_MAX, 8'hA5);
      put_halo(FACE_XL, 4'd0, 4'd0, 4'd0, 8'h00);
      put_halo(FACE_ZL, 4'd0, 4'd0, 4'd0, 8'h33);
      put_halo(FACE_YL, 4'd0, 4'd0, 4'd0, 8'h00);
      put_voxel(4'd1, 4'd0, 4'd0, 8'h00);
      put_voxel(4'd0, 4'd0, 4'd1, 8'h7E);
      put_voxel(4'd0, 4'd1, 4'd0, 8'h00);
      ask_faces(4'd0, 4'd0, 4'd0, 1'b0);
      send_ignored(1'b0);
      send_ignored(1'b1);
      // empty voxel, then a fully enclosed one at the far corner
      ask_faces(4'd1, 4'd0, 4'd0, 1'b0);
      ask_faces(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);

      for (int p = 0; p < PHASE_N; p++) begin
         if (p > 0) begin
            drain();
            write_empty_code(phase_code[p]);
         end
         calm = (p == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            random_beat();
            if (items_sent - phase_start >= CALM_ITEMS)
               calm = 1'b0;
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.owed.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/vfv_pkg.sv
hw/rtl/vfv_chan_if.sv
hw/rtl/vfv_front.sv
hw/rtl/vfv_queue.sv
hw/rtl/vfv_back.sv
hw/rtl/voxel_face_visibility.sv
tb/voxel_face_visibility_tb.sv
